@@ rtl/bkt_pkg.sv @@
// Shared types and constants for the best-k table with nearest Hamming search.
// Holds field widths, command and status codes, and the controller/datapath structs.
// No dependencies.
package bkt_pkg;

    // Field widths of the stream words
    localparam int CMD_W      = 2;
    localparam int GENE_W     = 16;
    localparam int KEY_W      = 32;
    localparam int STATUS_W   = 3;
    localparam int IDX_W      = 4;
    localparam int DIST_W     = 6;
    localparam int TOTAL_W    = 5;
    localparam int SIZE_W     = 5;
    localparam int ENTRY_W    = 2 * GENE_W + KEY_W;
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = CMD_W;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_USER_W = STATUS_W + 1;

    // Table size register after reset
    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    // Command codes carried in the input word
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED      = 3'd0,
        ST_REPLACED   = 3'd1,
        ST_DUPLICATE  = 3'd2,
        ST_NOT_BETTER = 3'd3,
        ST_DONE       = 3'd4
    } t_status;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;         // latch the input word, clear the accumulators
        logic scan;         // step the table walk
        logic shift_start;  // arm the move of entries toward the tail
        logic shift;        // step the entry move
        logic place;        // write the new entry at its slot
        logic finish;       // load the output register, update the count
    } t_ctrl_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_done;
        logic shift_done;
        logic plan_place;
        logic out_free;
    } t_dp_status;

endpackage

@@ rtl/best_k_table_nearest_hamming.sv @@
// Best-k table with nearest Hamming search: top level.
// Keeps up to belief_size candidates (two gene words and a signed Q16.16 key)
// sorted ascending by key; inserts reject duplicate gene pairs, a full table
// replaces its worst entry only with a strictly smaller key; a query returns the
// first held entry of least summed Hamming distance; clear empties the table.
// Input word: s_axis_* carries command in tuser, the gene pair and key in tdata.
// Result word: m_axis_* carries one result for every input word, in order.
// Flow: one item at a time. A query or insert walks the held entries, and an
// accepted insert then moves the entries behind its slot toward the tail. The
// walk reads the table RAM one entry a cycle through its single read port, and
// the move reads and writes one entry a cycle, so these two walks set the rate.
// A new word can be accepted in the cycle after the previous result is loaded.
// The result register holds a word until taken; a stalled receiver delays only
// the next result hand-off, the walk of a new item still runs.
// Reset (synchronous, active low) empties the table and sets belief_size to 16;
// table contents are not cleared and need no clearing pass.
// The user writes belief_size through i_cfg_we/i_cfg_wdata only while idle;
// the block does not check this. Depends on bkt_pkg, bkt_ctrl, bkt_dp, bkt_ram.
module best_k_table_nearest_hamming
    import bkt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int GENE_WIDTH  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [SIZE_W-1:0]     i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // gene_first[15:0], gene_second[31:16], fitness_key[63:32]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // command[1:0]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // near_index[3:0], near_distance[9:4], near_gene_first[25:10],
    // near_gene_second[41:26], near_fitness[73:42], entry_total[78:74], zero[79]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // op_status[2:0], found[3]
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    bkt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (dp_status),
        .o_cmd      (ctrl_cmd)
    );

    bkt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .GENE_WIDTH  (GENE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctrl_cmd),
        .o_status    (dp_status),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser)
    );

endmodule

@@ rtl/bkt_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the table entries; no package dependency.
module bkt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word and read one word through the output register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bkt_ctrl.sv @@
// Controller state machine for the best-k table: sequences accept, table walk,
// entry move, placement and result hand-off. Depends on bkt_pkg.
module bkt_ctrl
    import bkt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    if (i_status.plan_place) begin
                        o_cmd.shift_start = 1'b1;
                        n_state           = S_SHIFT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_status.shift_done) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ rtl/bkt_dp.sv @@
// Datapath for the best-k table: item latch, table RAM, walk counters,
// duplicate/position/nearest accumulators and output register.
// Depends on bkt_pkg and bkt_ram.
module bkt_dp
    import bkt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int GENE_WIDTH  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_status,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic [IN_USER_W-1:0]  i_in_user,
    input  logic                  i_cfg_we,
    input  logic [SIZE_W-1:0]     i_cfg_wdata,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic [OUT_USER_W-1:0] o_m_tuser
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NW = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [GENE_W-1:0] GMASK = (GENE_WIDTH >= GENE_W) ? {GENE_W{1'b1}} :
        GENE_W'((32'd1 << GENE_WIDTH) - 32'd1);
    localparam logic [NW-1:0] DEPTH_N = NW'(TABLE_DEPTH);

    // Latched item
    logic [CMD_W-1:0]  r_cmd;
    logic [GENE_W-1:0] r_g1;
    logic [GENE_W-1:0] r_g2;
    logic [KEY_W-1:0]  r_key;

    // Control state
    logic [NW-1:0]     r_held;
    logic [SIZE_W-1:0] r_size;
    logic [NW-1:0]     r_addr;
    logic              r_rvld;
    logic              r_out_valid;

    // Walk and accumulators
    logic [NW-1:0]     r_ridx;
    logic              r_dup;
    logic [NW-1:0]     r_pos;
    logic              r_found;
    logic [NW-1:0]     r_best_idx;
    logic [DIST_W-1:0] r_best_dist;
    logic [GENE_W-1:0] r_best_g1;
    logic [GENE_W-1:0] r_best_g2;
    logic [KEY_W-1:0]  r_best_key;

    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    logic [NW-1:0]     size_eff;
    logic [NW-1:0]     limit;
    logic [NW-1:0]     scan_n;
    logic [NW-1:0]     addr_m1;
    logic [NW-1:0]     plan_last;
    logic [NW-1:0]     n_held;
    logic              is_insert;
    logic              is_query;
    logic              is_clear;
    logic              full;
    t_status           plan_status;
    t_status           res_status;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IW-1:0]     ram_raddr;
    logic [ENTRY_W-1:0] rd_data;
    logic [GENE_W-1:0] rd_g1;
    logic [GENE_W-1:0] rd_g2;
    logic [KEY_W-1:0]  rd_key;
    logic [DIST_W-1:0] ham_dist;
    logic              near_ok;

    assign is_insert = (r_cmd == CMD_INSERT);
    assign is_query  = (r_cmd == CMD_QUERY);
    assign is_clear  = (r_cmd == CMD_CLEAR);

    // Clamp the size register into one..depth
    always_comb begin
        size_eff = NW'(r_size);
        if (size_eff == '0) begin
            size_eff = NW'(1);
        end else if (size_eff > DEPTH_N) begin
            size_eff = DEPTH_N;
        end
    end

    assign limit   = (r_held < size_eff) ? r_held : size_eff;
    assign full    = (r_held >= size_eff);
    assign addr_m1 = r_addr - NW'(1);

    // Insert checks every held entry; query only those in use
    always_comb begin
        scan_n = '0;
        if (is_insert) begin
            scan_n = r_held;
        end else if (is_query) begin
            scan_n = limit;
        end
    end

    // Decide what the insert does once the walk is over
    always_comb begin
        plan_status = ST_NOT_BETTER;
        plan_last   = '0;
        if (r_dup) begin
            plan_status = ST_DUPLICATE;
        end else if (!full) begin
            plan_status = ST_ADDED;
            plan_last   = r_held;
        end else if (r_pos < size_eff) begin
            plan_status = ST_REPLACED;
            plan_last   = size_eff - NW'(1);
        end
    end

    assign res_status = is_insert ? plan_status : ST_DONE;

    // Count after the item
    always_comb begin
        n_held = r_held;
        if (is_insert && (plan_status == ST_ADDED)) begin
            n_held = r_held + NW'(1);
        end else if (is_clear) begin
            n_held = '0;
        end
    end

    // Unpack the entry read back and measure its distance
    assign rd_g1    = rd_data[GENE_W-1:0];
    assign rd_g2    = rd_data[2*GENE_W-1:GENE_W];
    assign rd_key   = rd_data[ENTRY_W-1:2*GENE_W];
    assign ham_dist = DIST_W'($countones(rd_g1 ^ r_g1)) +
                      DIST_W'($countones(rd_g2 ^ r_g2));

    // Table RAM ports: moves during shift, new entry on place
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos[IW-1:0];
        ram_wdata = {r_key, r_g2, r_g1};
        if (i_cmd.shift && r_rvld) begin
            ram_we    = 1'b1;
            ram_waddr = IW'(r_ridx + NW'(1));
            ram_wdata = rd_data;
        end else if (i_cmd.place) begin
            ram_we = 1'b1;
        end
    end

    assign ram_raddr = i_cmd.shift ? addr_m1[IW-1:0] : r_addr[IW-1:0];

    bkt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    // Control registers: count, size, walk address, read valid, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_size      <= SIZE_RESET;
            r_addr      <= '0;
            r_rvld      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            if (i_cmd.finish) begin
                r_held <= n_held;
            end

            // Advance the walk address
            if (i_cmd.load) begin
                r_addr <= '0;
                r_rvld <= 1'b0;
            end else if (i_cmd.shift_start) begin
                r_addr <= plan_last;
                r_rvld <= 1'b0;
            end else if (i_cmd.scan && (r_addr < scan_n)) begin
                r_addr <= r_addr + NW'(1);
                r_rvld <= 1'b1;
            end else if (i_cmd.shift && (r_addr > r_pos)) begin
                r_addr <= addr_m1;
                r_rvld <= 1'b1;
            end else begin
                r_rvld <= 1'b0;
            end

            // Hold the result until taken
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign near_ok = is_query && r_found;

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_in_user[CMD_W-1:0];
            r_g1    <= i_in_data[GENE_W-1:0] & GMASK;
            r_g2    <= i_in_data[2*GENE_W-1:GENE_W] & GMASK;
            r_key   <= i_in_data[2*GENE_W+KEY_W-1:2*GENE_W];
            r_dup   <= 1'b0;
            r_pos   <= '0;
            r_found <= 1'b0;
        end

        // Track index of the entry in flight
        if (i_cmd.scan && (r_addr < scan_n)) begin
            r_ridx <= r_addr;
        end else if (i_cmd.shift && (r_addr > r_pos)) begin
            r_ridx <= addr_m1;
        end

        // Fold the returned entry into the accumulators
        if (i_cmd.scan && r_rvld) begin
            if (is_insert) begin
                if ((rd_g1 == r_g1) && (rd_g2 == r_g2)) begin
                    r_dup <= 1'b1;
                end
                if ((r_ridx < limit) && !($signed(r_key) < $signed(rd_key))) begin
                    r_pos <= r_ridx + NW'(1);
                end
            end else if ((r_ridx == '0) || (ham_dist < r_best_dist)) begin
                r_found     <= 1'b1;
                r_best_idx  <= r_ridx;
                r_best_dist <= ham_dist;
                r_best_g1   <= rd_g1;
                r_best_g2   <= rd_g2;
                r_best_key  <= rd_key;
            end
        end

        // Load the result word
        if (i_cmd.finish) begin
            r_out_user <= {near_ok, res_status};
            r_out_data <= {1'b0,
                           TOTAL_W'(n_held),
                           near_ok ? r_best_key : {KEY_W{1'b0}},
                           near_ok ? r_best_g2 : {GENE_W{1'b0}},
                           near_ok ? r_best_g1 : {GENE_W{1'b0}},
                           near_ok ? r_best_dist : {DIST_W{1'b0}},
                           near_ok ? r_best_idx[IDX_W-1:0] : {IDX_W{1'b0}}};
        end
    end

    assign o_status.scan_done  = (r_addr >= scan_n) && !r_rvld;
    assign o_status.shift_done = (r_addr <= r_pos) && !r_rvld;
    assign o_status.plan_place = is_insert &&
                                 ((plan_status == ST_ADDED) || (plan_status == ST_REPLACED));
    assign o_status.out_free   = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for best_k_table_nearest_hamming: directed words, then random phases.
// Keeps its own model of the sorted table and checks every result word field by field.
// Depends on bkt_pkg and the RTL top level.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bkt_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int DEPTH        = 16;
    localparam int RANDOM_WORDS = 700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 50;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One expected result word, unpacked
    typedef struct {
        t_status            status;
        logic               found;
        logic [IDX_W-1:0]   index;
        logic [DIST_W-1:0]  distance;
        logic [GENE_W-1:0]  gene_first;
        logic [GENE_W-1:0]  gene_second;
        logic [KEY_W-1:0]   fitness;
        logic [TOTAL_W-1:0] total;
    } t_table_result;

    // Sorted-table model plus the queue of results still owed by the block
    class best_k_scoreboard;
        logic [GENE_W-1:0]       first_store [DEPTH];
        logic [GENE_W-1:0]       second_store[DEPTH];
        logic signed [KEY_W-1:0] key_store   [DEPTH];
        int                      held;
        logic [SIZE_W-1:0]       size_reg;
        t_table_result           awaiting_results[$];
        int                      errors;

        function new();
            held     = 0;
            size_reg = SIZE_RESET;
            errors   = 0;
        endfunction

        function int size_in_use();
            if (size_reg == 0) return 1;
            if (size_reg > DEPTH) return DEPTH;
            return int'(size_reg);
        endfunction

        function void set_size(logic [SIZE_W-1:0] value);
            size_reg = value;
        endfunction

        function int pending();
            return awaiting_results.size();
        endfunction

        // Move entries pos..last-1 one slot toward the tail, then write at pos
        function void place_entry(int pos, int last, logic [GENE_W-1:0] g1,
                                  logic [GENE_W-1:0] g2, logic signed [KEY_W-1:0] key);
            for (int i = last; i > pos; i--) begin
                first_store[i]  = first_store[i-1];
                second_store[i] = second_store[i-1];
                key_store[i]    = key_store[i-1];
            end
            first_store[pos]  = g1;
            second_store[pos] = g2;
            key_store[pos]    = key;
        endfunction

        // Apply one accepted command word and queue the result it owes
        function void apply_command(logic [CMD_W-1:0] cmd, logic [GENE_W-1:0] g1,
                                    logic [GENE_W-1:0] g2, logic signed [KEY_W-1:0] key);
            t_table_result r;
            int            size;
            int            limit;
            int            pos;
            int            ham_dist;
            bit            dup;
            r.status      = ST_DONE;
            r.found       = 1'b0;
            r.index       = '0;
            r.distance    = '0;
            r.gene_first  = '0;
            r.gene_second = '0;
            r.fitness     = '0;
            size  = size_in_use();
            limit = (held < size) ? held : size;
            case (cmd)
                CMD_INSERT: begin
                    // duplicates are checked against every held entry, even past the size
                    dup = 1'b0;
                    for (int i = 0; i < held; i++)
                        if (first_store[i] == g1 && second_store[i] == g2) dup = 1'b1;
                    if (dup) begin
                        r.status = ST_DUPLICATE;
                    end else begin
                        // slot just after every key not greater than the new one
                        pos = 0;
                        for (int i = 0; i < limit; i++)
                            if (!(key < key_store[i])) pos = i + 1;
                        if (held < size) begin
                            place_entry(pos, held, g1, g2, key);
                            held++;
                            r.status = ST_ADDED;
                        end else if (pos < size) begin
                            place_entry(pos, size - 1, g1, g2, key);
                            r.status = ST_REPLACED;
                        end else begin
                            r.status = ST_NOT_BETTER;
                        end
                    end
                end
                CMD_QUERY: begin
                    for (int i = 0; i < limit; i++) begin
                        ham_dist = $countones(first_store[i] ^ g1) +
                                   $countones(second_store[i] ^ g2);
                        if (i == 0 || ham_dist < int'(r.distance)) begin
                            r.found       = 1'b1;
                            r.index       = i[IDX_W-1:0];
                            r.distance    = ham_dist[DIST_W-1:0];
                            r.gene_first  = first_store[i];
                            r.gene_second = second_store[i];
                            r.fitness     = key_store[i];
                        end
                    end
                end
                CMD_CLEAR: begin
                    held = 0;
                end
                default: begin
                end
            endcase
            r.total = held[TOTAL_W-1:0];
            awaiting_results.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        // Check one accepted result word against the oldest expectation
        task check_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
            t_table_result want;
            if (awaiting_results.size() == 0) begin
                report("result word with no expectation waiting");
                return;
            end
            want = awaiting_results.pop_front();
            compare_field("op_status", 32'(user[2:0]), 32'(want.status));
            compare_field("found", 32'(user[3]), 32'(want.found));
            compare_field("near_index", 32'(data[3:0]), 32'(want.index));
            compare_field("near_distance", 32'(data[9:4]), 32'(want.distance));
            compare_field("near_gene_first", 32'(data[25:10]), 32'(want.gene_first));
            compare_field("near_gene_second", 32'(data[41:26]), 32'(want.gene_second));
            compare_field("near_fitness", data[73:42], want.fitness);
            compare_field("entry_total", 32'(data[78:74]), 32'(want.total));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [SIZE_W-1:0]     i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    best_k_scoreboard book = new();
    bit               quiet_stretch;
    int               cycle_count = 0;

    best_k_table_nearest_hamming dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Track config writes, accepted commands and accepted results at each edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) book.set_size(i_cfg_wdata);
            if (s_axis_tvalid && s_axis_tready)
                book.apply_command(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                                   s_axis_tdata[63:32]);
            if (m_axis_tvalid && m_axis_tready) book.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    function automatic int idle_draw();
        return quiet_stretch ? 0 : int'($urandom_range(0, 16));
    endfunction

    // Receiver: stall a random number of cycles before taking each result word
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = idle_draw();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Present one command word after a random gap and hold it until accepted
    task automatic send_word(logic [CMD_W-1:0] cmd, logic [GENE_W-1:0] g1,
                             logic [GENE_W-1:0] g2, logic [KEY_W-1:0] key);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {key, g2, g1};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop valid and wait until every owed result word has been taken
    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (book.pending() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Directed words: extremes, ties, full table, size out of range and lowered
    task automatic run_directed();
        send_word(CMD_QUERY,  16'h0000, 16'h0000, 32'h0000_0000);   // query on empty table
        send_word(CMD_INSERT, 16'h0000, 16'h0000, 32'h7FFF_FFFF);
        send_word(CMD_INSERT, 16'hFFFF, 16'hFFFF, 32'h8000_0000);
        send_word(CMD_INSERT, 16'h0000, 16'h0000, 32'h0000_0001);   // duplicate pair
        send_word(CMD_INSERT, 16'h1234, 16'h5678, 32'h0000_0000);
        send_word(CMD_INSERT, 16'hABCD, 16'h0000, 32'h0000_0000);   // equal key goes after
        send_word(CMD_QUERY,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(CMD_QUERY,  16'h00FF, 16'hFF00, 32'h0000_0000);   // three entries tie, a nearer one wins
        send_word(CMD_UNUSED, 16'h5555, 16'hAAAA, 32'h1234_5678);
        send_word(CMD_CLEAR,  16'h0000, 16'h0000, 32'h0000_0000);
        finish_phase();
        write_size(5'd2);
        send_word(CMD_INSERT, 16'h0001, 16'h0001, 32'd5);
        send_word(CMD_INSERT, 16'h0002, 16'h0002, 32'd3);
        send_word(CMD_INSERT, 16'h0003, 16'h0003, 32'd5);           // full, equal to worst
        send_word(CMD_INSERT, 16'h0004, 16'h0004, 32'd4);           // full, replaces worst
        send_word(CMD_QUERY,  16'h0004, 16'h0004, 32'd0);
        finish_phase();
        // lower the size below the held count
        write_size(5'd1);
        send_word(CMD_INSERT, 16'h0002, 16'h0002, -32'sd100);       // duplicate pair while held exceeds size
        send_word(CMD_INSERT, 16'h0005, 16'h0005, -32'sd7);
        send_word(CMD_QUERY,  16'h0004, 16'h0004, 32'd0);
        send_word(CMD_INSERT, 16'h0006, 16'h0006, 32'h7FFF_FFFF);
        finish_phase();
        write_size(5'd0);
        send_word(CMD_QUERY,  16'h0000, 16'h0000, 32'd0);
        finish_phase();
        write_size(5'd31);
        send_word(CMD_INSERT, 16'h0007, 16'h0007, 32'd1);
        send_word(CMD_QUERY,  16'h0007, 16'h0007, 32'd0);
        send_word(CMD_CLEAR,  16'h0000, 16'h0000, 32'd0);
        finish_phase();
    endtask

    // Random words: mostly inserts and queries, genes often drawn from the held
    // entries or a tiny set so duplicates, near hits and full-table cases are common
    task automatic random_phase(int words);
        int                r;
        int                pick;
        int                idx;
        logic [CMD_W-1:0]  cmd;
        logic [GENE_W-1:0] g1;
        logic [GENE_W-1:0] g2;
        logic [KEY_W-1:0]  key;
        for (int n = 0; n < words; n++) begin
            r = $urandom_range(0, 99);
            if (r < 58)      cmd = CMD_INSERT;
            else if (r < 93) cmd = CMD_QUERY;
            else if (r < 97) cmd = CMD_CLEAR;
            else             cmd = CMD_UNUSED;

            pick = $urandom_range(0, 9);
            if (book.held > 0 && pick < 3) begin
                idx = $urandom_range(0, book.held - 1);
                g1  = book.first_store[idx];
                g2  = book.second_store[idx];
                if (pick == 2) g2 = g2 ^ (16'h1 << $urandom_range(0, 15));
            end else if (pick < 6) begin
                g1 = GENE_W'($urandom_range(0, 3));
                g2 = GENE_W'($urandom_range(0, 3));
            end else begin
                g1 = GENE_W'($urandom);
                g2 = GENE_W'($urandom);
            end

            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                key = KEY_W'($urandom_range(0, 8) - 4);
            end else if (pick == 3) begin
                case ($urandom_range(0, 3))
                    0:       key = 32'h8000_0000;
                    1:       key = 32'h7FFF_FFFF;
                    2:       key = 32'h0000_0000;
                    default: key = 32'hFFFF_FFFF;
                endcase
            end else begin
                key = $urandom;
            end
            send_word(cmd, g1, g2, key);
        end
    endtask

    initial begin
        int sent;
        int words;
        quiet_stretch = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        // Random phases, each under a fresh table size
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            words         = $urandom_range(30, 70);
            quiet_stretch = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 7))
                0:       write_size(5'd16);
                1:       write_size(5'd1);
                2:       write_size(5'd2);
                3:       write_size(5'd4);
                4:       write_size(5'd0);
                5:       write_size(SIZE_W'($urandom_range(17, 31)));
                default: write_size(SIZE_W'($urandom_range(3, 16)));
            endcase
            random_phase(words);
            finish_phase();
            sent += words;
        end

        quiet_stretch = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.errors == 0 && book.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
